FILE: rtl/ice_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ice_pkg
// Shared constants, types and helpers of the 6x6 clamp-to-edge convolution.
// ----------------------------------------------------------------------------
package ice_pkg;

    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;
    localparam int WIN          = 6;
    localparam int LINES        = 6;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int VAL_W     = 18;
    localparam int IDX_W     = 10;
    localparam int CSUM_W    = 15;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = CFG_IDX_W'(1);
    localparam logic [CFG_W-1:0]     CFG_SIZE_RST   = CFG_W'(1024);

    // stage 1 beat: pixel plus where it sits in the frame
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [2:0]       rmod;     // row modulo 6
        logic [2:0]       rsat;     // min(row, 5)
        logic [1:0]       csat;     // min(col, 2)
        logic             last_row;
        logic             last_col;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_s1;

    function automatic logic [6:0] row_weight(input int k);
        logic [6:0] w;
        case (k)
            0:       w = 7'd64;
            1:       w = 7'd32;
            2:       w = 7'd16;
            3:       w = 7'd8;
            4:       w = 7'd2;
            5:       w = 7'd1;
            default: w = 7'd0;
        endcase
        return w;
    endfunction

    // line holding row R-5+j, given R mod 6
    function automatic logic [2:0] line_of(input logic [2:0] rmod, input int j);
        logic [3:0] t;
        t = 4'(rmod) + 4'(j + 1);
        if (t >= 4'(LINES)) begin
            t = t - 4'(LINES);
        end
        return t[2:0];
    endfunction

endpackage

FILE: rtl/ice_line_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ice_line_buf
// Six line memories, one per row modulo 6; all read at one column per beat.
// ----------------------------------------------------------------------------
module ice_line_buf #(
    parameter int MAX_COLS = ice_pkg::DEF_MAX_COLS
) (
    input  logic                                            i_clk,
    input  logic                                            i_en,
    input  logic [2:0]                                      i_wline,
    input  logic [$clog2(MAX_COLS)-1:0]                     i_addr,
    input  logic [ice_pkg::PIX_W-1:0]                       i_wdata,
    output logic [ice_pkg::LINES-1:0][ice_pkg::PIX_W-1:0]   o_rdata
);
    import ice_pkg::*;

    for (genvar g = 0; g < LINES; g++) begin : g_line
        logic [PIX_W-1:0] r_mem [MAX_COLS];

        always_ff @(posedge i_clk) begin
            if (i_en && (i_wline == 3'(g))) begin
                r_mem[i_addr] <= i_wdata;
            end
            if (i_en) begin
                o_rdata[g] <= r_mem[i_addr];
            end
        end
    end

endmodule

FILE: rtl/ice_col_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ice_col_sum
// Row-weighted vertical sums of one column for output rows R-2, R-1 and R.
// ----------------------------------------------------------------------------
module ice_col_sum (
    input  ice_pkg::t_s1                                    i_s1,
    input  logic [ice_pkg::LINES-1:0][ice_pkg::PIX_W-1:0]   i_rdata,
    output logic [2:0][ice_pkg::CSUM_W-1:0]                 o_csum
);
    import ice_pkg::*;

    logic [WIN-1:0][PIX_W-1:0] p;
    logic [PIX_W-1:0]          row0;

    // p[j] = pixel of row clamp(R-5+j); top rows clamp to row 0
    always_comb begin
        row0 = (i_s1.rsat == 3'd0) ? i_s1.pixel : i_rdata[0];
        for (int j = 0; j < WIN - 1; j++) begin
            if (4'(i_s1.rsat) + 4'(j) < 4'(WIN - 1)) begin
                p[j] = row0;
            end else begin
                p[j] = i_rdata[line_of(i_s1.rmod, j)];
            end
        end
        p[WIN-1] = i_s1.pixel;
    end

    // bottom clamp on the last row: offset d repeats the newest row
    always_comb begin
        for (int d = 0; d < 3; d++) begin
            o_csum[d] = '0;
            for (int k = 0; k < WIN; k++) begin
                o_csum[d] = o_csum[d] + CSUM_W'(row_weight(k)) *
                            CSUM_W'(p[(k + d > WIN - 1) ? WIN - 1 : k + d]);
            end
        end
    end

endmodule

FILE: rtl/ice_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ice_emit
// Column-sum windows, result sequencing and the output register.
// ----------------------------------------------------------------------------
module ice_emit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  ice_pkg::t_s1                      i_s1,
    input  logic [2:0][ice_pkg::CSUM_W-1:0]   i_csum,
    input  logic                              i_stall,
    output logic                              o_free,
    output logic                              o_valid,
    output logic [ice_pkg::VAL_W-1:0]         o_out_value,
    output logic [ice_pkg::IDX_W-1:0]         o_out_row,
    output logic [ice_pkg::IDX_W-1:0]         o_out_col,
    output logic                              o_run_last
);
    import ice_pkg::*;

    logic [2:0][WIN-1:0][CSUM_W-1:0] r_hs;
    logic             r_job_valid;
    logic [1:0]       r_d, r_e, r_e_lo, r_d_hi, r_e_hi;
    logic [IDX_W-1:0] r_row_base, r_col_base;

    logic             out_free, job_last;
    logic [VAL_W-1:0] sum;
    logic             rows_ok, cols_ok;
    logic [1:0]       n_d_lo, n_d_hi, n_e_lo, n_e_hi;

    assign out_free = !o_valid || !i_stall;
    assign job_last = (r_d == r_d_hi) && (r_e == r_e_hi);
    assign o_free   = !r_job_valid || (out_free && job_last);

    // horizontal sum with right clamp for column offset e
    always_comb begin
        sum = '0;
        for (int l = 0; l < WIN; l++) begin
            sum = sum + VAL_W'(r_hs[r_d][(l + int'(r_e) > WIN - 1) ?
                                        WIN - 1 : l + int'(r_e)]);
        end
    end

    always_comb begin
        rows_ok = i_s1.last_row || (i_s1.rsat >= 3'd2);
        cols_ok = i_s1.last_col || (i_s1.csat == 2'd2);
        n_d_hi  = i_s1.last_row ? 2'd2 : 2'd0;
        n_e_hi  = i_s1.last_col ? 2'd2 : 2'd0;
        n_d_lo  = (i_s1.last_row && (i_s1.rsat < 3'd2)) ? 2'd2 - i_s1.rsat[1:0] : 2'd0;
        n_e_lo  = (i_s1.last_col && (i_s1.csat < 2'd2)) ? 2'd2 - i_s1.csat : 2'd0;
    end

    // windows: left clamp reloads all taps at column 0
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int d = 0; d < 3; d++) begin
                for (int j = 0; j < WIN - 1; j++) begin
                    r_hs[d][j] <= (i_s1.csat == 2'd0) ? i_csum[d] : r_hs[d][j+1];
                end
                r_hs[d][WIN-1] <= i_csum[d];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            if (out_free) begin
                o_valid <= r_job_valid;
            end
            if (r_job_valid && out_free) begin
                if (r_e == r_e_hi) begin
                    r_e <= r_e_lo;
                    r_d <= r_d + 2'd1;
                end else begin
                    r_e <= r_e + 2'd1;
                end
                if (job_last) begin
                    r_job_valid <= 1'b0;
                end
            end
            if (i_adv) begin
                r_job_valid <= rows_ok && cols_ok;
                r_d         <= n_d_lo;
                r_e         <= n_e_lo;
                r_e_lo      <= n_e_lo;
                r_d_hi      <= n_d_hi;
                r_e_hi      <= n_e_hi;
                r_row_base  <= i_s1.row - IDX_W'(2);
                r_col_base  <= i_s1.col - IDX_W'(2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_job_valid && out_free) begin
            o_out_value <= sum;
            o_out_row   <= r_row_base + IDX_W'(r_d);
            o_out_col   <= r_col_base + IDX_W'(r_e);
            o_run_last  <= job_last;
        end
    end

endmodule

FILE: rtl/image_convolution_clamp_edge.sv
`timescale 1ns / 1ps
// Registers on the path: stage 1 with the line read, windows, output register.
// Throughput: 1 pixel per cycle while the output is not stalled; a last-column or
// last-row pixel gives up to 3 results and the frame's last pixel up to 9, one per
// cycle through the single output register, with input stalled while they drain.
// Reset: position counters to zero, sizes to 1024; line memories not cleared.
// ----------------------------------------------------------------------------
// image_convolution_clamp_edge
// Streaming 6x6 row-weighted window sum with clamp-to-edge borders.
// ----------------------------------------------------------------------------
module image_convolution_clamp_edge #(
    parameter int MAX_COLS = ice_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = ice_pkg::DEF_MAX_ROWS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [ice_pkg::PIX_W-1:0]         i_pixel,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [ice_pkg::VAL_W-1:0]         o_out_value,
    output logic [ice_pkg::IDX_W-1:0]         o_out_row,
    output logic [ice_pkg::IDX_W-1:0]         o_out_col,
    output logic                              o_run_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ice_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ice_pkg::CFG_W-1:0]         i_cfg_data
);
    import ice_pkg::*;

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int SWC = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int SWR = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

    logic [CFG_W-1:0] r_image_cols, r_image_rows;
    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic [2:0]       r_rmod, n_rmod;
    logic             r_s1_valid;
    t_s1              r_s1;

    logic [SWC-1:0] eff_cols;
    logic [SWR-1:0] eff_rows;
    logic [CW-1:0]  col_last;
    logic [RW-1:0]  row_last;
    logic           last_col, last_row, accept, s1_adv, s2_free, cfg_hit;
    logic [LINES-1:0][PIX_W-1:0] rdata;
    logic [2:0][CSUM_W-1:0]      csum;

    assign o_cfg_ready = 1'b1;
    assign cfg_hit = i_cfg_valid && ((i_cfg_index == CFG_IMAGE_COLS) ||
                                     (i_cfg_index == CFG_IMAGE_ROWS));

    always_comb begin
        if (r_image_cols == '0) begin
            eff_cols = SWC'(1);
        end else if (SWC'(r_image_cols) > SWC'(MAX_COLS)) begin
            eff_cols = SWC'(MAX_COLS);
        end else begin
            eff_cols = SWC'(r_image_cols);
        end
        if (r_image_rows == '0) begin
            eff_rows = SWR'(1);
        end else if (SWR'(r_image_rows) > SWR'(MAX_ROWS)) begin
            eff_rows = SWR'(MAX_ROWS);
        end else begin
            eff_rows = SWR'(r_image_rows);
        end
        col_last = CW'(eff_cols - SWC'(1));
        row_last = RW'(eff_rows - SWR'(1));
    end

    assign last_col = (r_col == col_last);
    assign last_row = (r_row == row_last);
    assign s1_adv   = r_s1_valid && s2_free;
    assign o_stall  = r_s1_valid && !s2_free;
    assign accept   = i_valid && !o_stall;

    always_comb begin
        n_col  = r_col + CW'(1);
        n_row  = r_row;
        n_rmod = r_rmod;
        if (last_col) begin
            n_col  = '0;
            n_row  = last_row ? '0 : r_row + RW'(1);
            n_rmod = (last_row || (r_rmod == 3'(LINES - 1))) ? 3'd0 : r_rmod + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_cols <= CFG_SIZE_RST;
            r_image_rows <= CFG_SIZE_RST;
            r_col        <= '0;
            r_row        <= '0;
            r_rmod       <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_rmod <= n_rmod;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            // a write to either size register restarts the frame
            if (cfg_hit) begin
                if (i_cfg_index == CFG_IMAGE_COLS) begin
                    r_image_cols <= i_cfg_data;
                end else begin
                    r_image_rows <= i_cfg_data;
                end
                r_col  <= '0;
                r_row  <= '0;
                r_rmod <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.pixel    <= i_pixel;
            r_s1.rmod     <= r_rmod;
            r_s1.rsat     <= (r_row >= RW'(WIN - 1)) ? 3'(WIN - 1) : 3'(r_row);
            r_s1.csat     <= (r_col >= CW'(2)) ? 2'd2 : 2'(r_col);
            r_s1.last_row <= last_row;
            r_s1.last_col <= last_col;
            r_s1.row      <= IDX_W'(r_row);
            r_s1.col      <= IDX_W'(r_col);
        end
    end

    ice_line_buf #(
        .MAX_COLS (MAX_COLS)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_wline (r_rmod),
        .i_addr  (r_col),
        .i_wdata (i_pixel),
        .o_rdata (rdata)
    );

    ice_col_sum u_col_sum (
        .i_s1    (r_s1),
        .i_rdata (rdata),
        .o_csum  (csum)
    );

    ice_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (s1_adv),
        .i_s1        (r_s1),
        .i_csum      (csum),
        .i_stall     (i_stall),
        .o_free      (s2_free),
        .o_valid     (o_valid),
        .o_out_value (o_out_value),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_run_last  (o_run_last)
    );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming 6x6 clamp-to-edge convolution. An
// in-bench model of the line store and the frame counters predicts every
// result beat. Each result beat is checked in order against that prediction.
// Frame sizes are changed between phases through the config channel. Both
// streams idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import ice_pkg::*;

    localparam int TB_MAX_COLS = 1024;
    localparam int TB_MAX_ROWS = 1024;
    localparam int IDLE_LIMIT  = 3000;
    localparam int DRAIN_WAIT  = 10;
    localparam int EDGE_RUN    = 96;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

    typedef struct {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } t_window_sum;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [PIX_W-1:0]     i_pixel;
    logic                 o_valid;
    logic                 i_stall;
    logic [VAL_W-1:0]     o_out_value;
    logic [IDX_W-1:0]     o_out_row;
    logic [IDX_W-1:0]     o_out_col;
    logic                 o_run_last;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    image_convolution_clamp_edge i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_value (o_out_value),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_run_last  (o_run_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic [PIX_W-1:0] pix_lines [0:LINES*TB_MAX_COLS-1];
    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] rows_reg;
    int               next_row;
    int               next_col;

    t_window_sum pending_sums[$];
    int  errors;
    int  pixels_sent;
    int  sums_checked;
    int  cfg_writes;
    int  idle_cycles;
    bit  calm_input;
    bit  calm_output;
    int  stall_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int eff_size(input logic [CFG_W-1:0] v, input int maxv);
        if (v == '0) return 1;
        if (int'(v) > maxv) return maxv;
        return int'(v);
    endfunction

    function automatic int clamp(input int v, input int n);
        if (v < 0) return 0;
        if (v >= n) return n - 1;
        return v;
    endfunction

    function automatic logic [VAL_W-1:0] window_total(input int r, input int c,
                                                      input int h, input int w);
        int unsigned acc;
        int rr;
        int cc;
        int unsigned wt;
        acc = 0;
        for (int k = 0; k < WIN; k++) begin
            rr = clamp(r + k - WIN / 2, h);
            case (k)
                0: wt = 64;
                1: wt = 32;
                2: wt = 16;
                3: wt = 8;
                4: wt = 2;
                default: wt = 1;
            endcase
            for (int l = 0; l < WIN; l++) begin
                cc = clamp(c + l - WIN / 2, w);
                acc += int'(pix_lines[(rr % LINES) * TB_MAX_COLS + cc]) * wt;
            end
        end
        return acc[VAL_W-1:0];
    endfunction

    // store the pixel, queue every window it completes, advance the position
    task automatic convolve_pixel(input logic [PIX_W-1:0] p);
        int w;
        int h;
        int rr;
        int cc;
        int rlo;
        int rhi;
        int clo;
        int chi;
        int n;
        t_window_sum s;
        w = eff_size(cols_reg, TB_MAX_COLS);
        h = eff_size(rows_reg, TB_MAX_ROWS);
        rr = (next_row >= h) ? h - 1 : next_row;
        cc = (next_col >= w) ? w - 1 : next_col;
        pix_lines[(rr % LINES) * TB_MAX_COLS + cc] = p;
        rlo = rr - 2;
        rhi = (rr == h - 1) ? rr : rr - 2;
        clo = cc - 2;
        chi = (cc == w - 1) ? cc : cc - 2;
        if (rlo < 0) rlo = 0;
        if (clo < 0) clo = 0;
        n = 0;
        for (int r = rlo; r <= rhi; r++) begin
            for (int c = clo; c <= chi; c++) begin
                s.value = window_total(r, c, h, w);
                s.row   = IDX_W'(r);
                s.col   = IDX_W'(c);
                s.last  = 1'b0;
                pending_sums.push_back(s);
                n++;
            end
        end
        if (n > 0) pending_sums[$].last = 1'b1;
        if (cc >= w - 1) begin
            next_col = 0;
            next_row = (rr >= h - 1) ? 0 : rr + 1;
        end else begin
            next_col = cc + 1;
            next_row = rr;
        end
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] p);
        int gap;
        gap = calm_input ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= p;
        do @(posedge i_clk); while (o_stall);
        convolve_pixel(p);
        pixels_sent++;
    endtask

    // only while idle: all results in, pipeline flushed
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        i_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_IMAGE_COLS) cols_reg = d;
        if (idx == CFG_IMAGE_ROWS) rows_reg = d;
        if (idx == CFG_IMAGE_COLS || idx == CFG_IMAGE_ROWS) begin
            next_row = 0;
            next_col = 0;
        end
        cfg_writes++;
    endtask

    task automatic set_size(input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] r);
        write_cfg(CFG_IMAGE_COLS, c);
        write_cfg(CFG_IMAGE_ROWS, r);
    endtask

    task automatic test_default_size();
        // 1024x1024 after reset: first row gives no results yet
        for (int i = 0; i < 4; i++) send_pixel(PIX_W'($urandom_range(0, 255)));
    endtask

    task automatic test_directed();
        set_size(CFG_W'(0), CFG_W'(0));
        send_pixel(8'd0);
        send_pixel(8'd255);
        set_size(CFG_W'(3), CFG_W'(3));
        for (int i = 0; i < 9; i++) send_pixel(8'd255);
        // unused indexes must not restart the frame
        for (int i = 0; i < 4; i++) send_pixel(8'd0);
        write_cfg(CFG_SPARE_A, CFG_W'(5));
        write_cfg(CFG_SPARE_B, CFG_W'(2047));
        for (int i = 0; i < 5; i++) send_pixel(8'hA5 ^ PIX_W'(i));
        set_size(CFG_W'(2), CFG_W'(1));
        send_pixel(8'd1);
        send_pixel(8'd128);
    endtask

    task automatic test_wide_row();
        set_size(CFG_W'(2047), CFG_W'(1));
        for (int i = 0; i < EDGE_RUN; i++) send_pixel(PIX_W'($urandom_range(0, 255)));
    endtask

    task automatic test_tall_column();
        set_size(CFG_W'(1), CFG_W'(2047));
        for (int i = 0; i < EDGE_RUN; i++) send_pixel(PIX_W'($urandom_range(0, 255)));
    endtask

    task automatic test_random_frames(input int target);
        int start;
        int c;
        int r;
        int n;
        int mode;
        logic [PIX_W-1:0] p;
        start = pixels_sent;
        while (pixels_sent - start < target) begin
            calm_input  = ($urandom_range(0, 3) == 0);
            calm_output = ($urandom_range(0, 3) == 0);
            c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 8);
            r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 6);
            set_size(CFG_W'(c), CFG_W'(r));
            n = eff_size(CFG_W'(c), TB_MAX_COLS) * eff_size(CFG_W'(r), TB_MAX_ROWS);
            n = n * $urandom_range(1, 2);
            if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
            mode = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
                case (mode)
                    0: p = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
                    default: p = PIX_W'($urandom_range(0, 255));
                endcase
                send_pixel(p);
            end
        end
        calm_input  = 1'b0;
        calm_output = 1'b0;
    endtask

    // result side: random stall per beat, in-order check
    always @(posedge i_clk) begin
        t_window_sum e;
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_sums.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: value %0d row %0d col %0d last %0d",
                             o_out_value, o_out_row, o_out_col, o_run_last);
            end else begin
                e = pending_sums.pop_front();
                if (e.value !== o_out_value || e.row !== o_out_row ||
                    e.col !== o_out_col || e.last !== o_run_last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0d r%0d c%0d l%0d, got %0d r%0d c%0d l%0d",
                                 e.value, e.row, e.col, e.last,
                                 o_out_value, o_out_row, o_out_col, o_run_last);
                end
            end
            sums_checked++;
            stall_left = calm_output ? 0 : $urandom_range(0, 14);
            i_stall <= (stall_left > 0);
        end else if (i_stall) begin
            stall_left--;
            if (stall_left <= 0) i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_pixel     <= '0;
        i_stall     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_IMAGE_COLS;
        i_cfg_data  <= '0;
        for (int i = 0; i < LINES * TB_MAX_COLS; i++) pix_lines[i] = '0;
        cols_reg     = CFG_SIZE_RST;
        rows_reg     = CFG_SIZE_RST;
        next_row     = 0;
        next_col     = 0;
        errors       = 0;
        pixels_sent  = 0;
        sums_checked = 0;
        cfg_writes   = 0;
        idle_cycles  = 0;
        stall_left   = 0;
        calm_input   = 1'b0;
        calm_output  = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_size();
        test_directed();
        test_wide_row();
        test_tall_column();
        test_random_frames(210);

        i_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("run covered %0d pixels, %0d result beats, %0d config writes",
                 pixels_sent, sums_checked, cfg_writes);
        $display("frames from 1x1 to 12x12, out-of-range sizes, long row and column runs");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ice_pkg.sv
rtl/ice_line_buf.sv
rtl/ice_col_sum.sv
rtl/ice_emit.sv
rtl/image_convolution_clamp_edge.sv
tb/sv/testbench.sv
